FILE: rtl/slid_pkg.sv
package slid_pkg;

   typedef logic signed [31:0] value_type;
   typedef logic [1:0]         status_type;
   typedef logic               command_type;

   localparam command_type CMD_INSERT = 1'b0;
   localparam command_type CMD_DELETE = 1'b1;

   localparam status_type STATUS_DONE    = 2'd0;
   localparam status_type STATUS_FULL    = 2'd1;
   localparam status_type STATUS_MISSING = 2'd2;

endpackage

FILE: rtl/slid_channels.sv
interface slid_req_if
   import slid_pkg::*;
   ();
   logic        valid;
   logic        ready;
   command_type command;
   value_type   value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface slid_rsp_if
   import slid_pkg::*;
   #(parameter int COUNT_W = 7)
   ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [COUNT_W-1:0] entry_count;
   value_type          smallest;
   value_type          largest;

   modport source (output valid, output status, output entry_count, output smallest,
                   output largest, input ready);
   modport sink   (input valid, input status, input entry_count, input smallest,
                   input largest, output ready);
endinterface

FILE: rtl/sorted_list_insert_delete.sv
// Sorted table of signed 32-bit values, ascending, duplicates allowed.
// req_bus carries one word per operation: command (insert or delete) and
// value. rsp_bus returns one word per operation: status (done, table full,
// value not found), entry count after the operation, and the smallest and
// largest stored values (zero when the table is empty).
// The table lives in one single-port-read, single-port-write memory with a
// registered read. Each operation walks the memory one entry at a time:
// an insert moves entries up from the top until its slot is found, a delete
// searches from the bottom and then moves the entries above the hit down.
// After the walk, the smallest and largest stored values are read back (or
// set to zero for an empty table) and the response is loaded; a full-table
// insert or an empty-table delete skips the walk. One operation is in flight
// at a time; the next request is taken the cycle after the response is loaded.
// Reset empties the table at once; no clearing pass is needed.
// The response sits in an output register: a new request is taken while it
// waits, and the block stalls only when the next response is ready before
// the previous one has been taken.
module sorted_list_insert_delete
   import slid_pkg::*;
   #(parameter int DEPTH = 64)
   (
   input  logic        clock,
   input  logic        reset,
   slid_req_if.sink    req_bus,
   slid_rsp_if.source  rsp_bus
   );

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] ONE  = CW'(1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_RD  = 4'd1;
   localparam logic [3:0] S_INS_CMP = 4'd2;
   localparam logic [3:0] S_DEL_RD  = 4'd3;
   localparam logic [3:0] S_DEL_CMP = 4'd4;
   localparam logic [3:0] S_SH_RD   = 4'd5;
   localparam logic [3:0] S_SH_WR   = 4'd6;
   localparam logic [3:0] S_SUM     = 4'd7;
   localparam logic [3:0] S_LO      = 4'd8;
   localparam logic [3:0] S_HI      = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0]    state_ff, state_in;
   value_type     val_ff, val_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   status_type    status_ff, status_in;
   value_type     lo_ff, lo_in;
   value_type     hi_ff, hi_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   value_type     rsp_lo_ff, rsp_lo_in;
   value_type     rsp_hi_ff, rsp_hi_in;

   value_type     entries_mem [DEPTH];
   value_type     rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   value_type     mem_wdata;

   logic          req_fire;
   logic          rsp_free;
   logic [CW-1:0] idx_dec;
   logic [CW-1:0] idx_inc;
   logic [CW-1:0] cnt_dec;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign idx_dec  = idx_ff - ONE;
   assign idx_inc  = idx_ff + ONE;
   assign cnt_dec  = cnt_ff - ONE;

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.entry_count = rsp_count_ff;
   assign rsp_bus.smallest    = rsp_lo_ff;
   assign rsp_bus.largest     = rsp_hi_ff;

   always_comb begin
      state_in      = state_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_hi_in     = rsp_hi_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[AW-1:0];
      mem_wdata     = val_ff;
      mem_raddr     = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               val_in    = req_bus.value;
               status_in = STATUS_DONE;
               if (req_bus.command == CMD_INSERT) begin
                  idx_in = cnt_ff;
                  if (cnt_ff == FULL) begin
                     status_in = STATUS_FULL;
                     state_in  = S_SUM;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end else begin
                  idx_in = '0;
                  if (cnt_ff == '0) begin
                     status_in = STATUS_MISSING;
                     state_in  = S_SUM;
                  end else begin
                     state_in = S_DEL_RD;
                  end
               end
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               mem_we   = 1'b1;
               cnt_in   = cnt_ff + ONE;
               state_in = S_SUM;
            end else begin
               mem_raddr = idx_dec[AW-1:0];
               state_in  = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            mem_we = 1'b1;
            if (rd_data_ff > val_ff) begin
               mem_wdata = rd_data_ff;
               idx_in    = idx_dec;
               state_in  = S_INS_RD;
            end else begin
               cnt_in   = cnt_ff + ONE;
               state_in = S_SUM;
            end
         end
         S_DEL_RD: begin
            state_in = S_DEL_CMP;
         end
         S_DEL_CMP: begin
            if (rd_data_ff == val_ff) begin
               state_in = S_SH_RD;
            end else if (idx_inc == cnt_ff) begin
               status_in = STATUS_MISSING;
               state_in  = S_SUM;
            end else begin
               idx_in   = idx_inc;
               state_in = S_DEL_RD;
            end
         end
         S_SH_RD: begin
            if (idx_inc < cnt_ff) begin
               mem_raddr = idx_inc[AW-1:0];
               state_in  = S_SH_WR;
            end else begin
               cnt_in   = cnt_dec;
               state_in = S_SUM;
            end
         end
         S_SH_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            idx_in    = idx_inc;
            state_in  = S_SH_RD;
         end
         S_SUM: begin
            if (cnt_ff == '0) begin
               lo_in    = '0;
               hi_in    = '0;
               state_in = S_DONE;
            end else begin
               mem_raddr = '0;
               state_in  = S_LO;
            end
         end
         S_LO: begin
            lo_in     = rd_data_ff;
            mem_raddr = cnt_dec[AW-1:0];
            state_in  = S_HI;
         end
         S_HI: begin
            hi_in    = rd_data_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = cnt_ff;
               rsp_lo_in     = lo_ff;
               rsp_hi_in     = hi_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_hi_ff     <= rsp_hi_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entries_mem[mem_raddr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL)
      else $error("entry count above table depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FULL |-> rsp_count_ff == FULL)
      else $error("full status with table not full");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_count_ff == '0 |-> rsp_lo_ff == '0 && rsp_hi_ff == '0)
      else $error("empty table reports nonzero bounds");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |=> $stable(cnt_ff))
      else $error("entry count moved while idle");

endmodule
